FILE: rtl/core/tsps_pkg.sv
// tsps_pkg: shared types and constants for the transport stream packet parser.
// No dependencies.
package tsps_pkg;

	localparam logic [7:0] SYNC_MARK   = 8'h47;
	localparam int         POS_W       = 8;
	localparam int         OFF_W       = 9;
	localparam int         HDR_W       = 24;
	localparam int         DATA_W      = 32;
	localparam logic [OFF_W-1:0] OFF_NO_AF = 9'd4;
	localparam logic [OFF_W-1:0] OFF_AF    = 9'd5;

	typedef struct packed {
		logic        valid;
		logic [7:0]  payload_byte;
		logic [12:0] stream_id;
		logic        error_flag;
		logic        unit_start_flag;
		logic        priority_flag;
		logic [1:0]  scrambling_mode;
		logic [3:0]  continuity_count;
		logic        first_payload;
		logic        last_of_packet;
	} result_t;

	typedef struct packed {
		logic             in_packet;
		logic [POS_W-1:0] pos;
	} status_t;

endpackage

FILE: rtl/core/ts_packet_sync_parser.sv
// ts_packet_sync_parser: top level, byte input register, parser and result register.
// Depends on tsps_pkg, tsps_parse, tsps_out_reg.
//
//  channel  dir  beat
//  s_*      in   one stream byte (tdata[7:0] = data_byte)
//  m_*      out  one payload byte with header tags, tlast = last byte of packet
//
// One byte per clock unless the output stalls; input register, then result register.
// The byte in the input register is decoded and the packet state advanced in the same cycle.
// Bytes that yield no result retire even while the output is stalled; a payload byte
// waits in the input register until the result register frees.
// Reset (arst_n low) returns the parser to sync hunting and empties both registers.
module ts_packet_sync_parser #(
	parameter int PACKET_BYTES = 188
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // data_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// payload_byte, stream_id, error_flag, unit_start_flag, priority_flag,
	// scrambling_mode, continuity_count, zero pad
	output logic [tsps_pkg::DATA_W-1:0]  m_tdata,
	output logic                         m_tlast,  // last_of_packet
	output logic [0:0]                   m_tuser   // first_payload
);
	import tsps_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_busy;
	logic       advance;
	result_t    res;
	status_t    status;

	assign advance  = valid_s1 && !(res.valid && out_busy);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	tsps_parse #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_s1),
		.step      (advance),
		.res       (res),
		.status    (status)
	);

	tsps_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.load     (advance && res.valid),
		.busy     (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.pos <= POS_W'(PACKET_BYTES - 1))
		else $error("byte position past end of packet");

	a_hunt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!status.in_packet |-> status.pos == '0)
		else $error("position not cleared while hunting");

	a_res_in_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> status.in_packet)
		else $error("payload decoded outside a packet");

	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (m_tvalid && !m_tready && res.valid))
		else $error("input byte held without output stall");

endmodule

FILE: rtl/core/tsps_parse.sv
// tsps_parse: packet state (sync, position, header, payload offset) and byte decode.
// Depends on tsps_pkg.
module tsps_parse #(
	parameter int PACKET_BYTES = 188
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               step,
	output tsps_pkg::result_t  res,
	output tsps_pkg::status_t  status
);
	import tsps_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

	logic             in_packet_q;
	logic [POS_W-1:0] pos_q;
	logic [HDR_W-1:0] hdr_q;
	logic [OFF_W-1:0] off_q;
	logic [1:0]       afc;
	logic             is_hdr;
	logic             is_aflen;
	logic             at_last;
	logic [OFF_W-1:0] pos_ext;

	assign afc      = hdr_q[5:4];
	assign is_hdr   = (pos_q >= POS_W'(1)) && (pos_q <= POS_W'(3));
	assign is_aflen = (pos_q == POS_W'(4)) && afc[1];
	assign at_last  = pos_q >= LAST_POS;
	assign pos_ext  = {1'b0, pos_q};

	always_comb begin
		res                  = '0;
		res.valid            = in_packet_q && !is_hdr && !is_aflen && afc[0] && (pos_ext >= off_q);
		res.payload_byte     = data_byte;
		res.stream_id        = hdr_q[20:8];
		res.error_flag       = hdr_q[23];
		res.unit_start_flag  = hdr_q[22];
		res.priority_flag    = hdr_q[21];
		res.scrambling_mode  = hdr_q[7:6];
		res.continuity_count = hdr_q[3:0];
		res.first_payload    = pos_ext == off_q;
		res.last_of_packet   = at_last;
	end

	assign status.in_packet = in_packet_q;
	assign status.pos       = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			pos_q       <= '0;
			hdr_q       <= '0;
			off_q       <= '0;
		end else if (step) begin
			if (!in_packet_q) begin
				if (data_byte == SYNC_MARK) begin
					in_packet_q <= 1'b1;
					pos_q       <= POS_W'(1);
				end
			end else begin
				if (is_hdr) begin
					hdr_q <= {hdr_q[15:0], data_byte};
					if (pos_q == POS_W'(3))
						off_q <= data_byte[5] ? OFF_AF : OFF_NO_AF;
				end else if (is_aflen) begin
					off_q <= OFF_AF + {1'b0, data_byte};
				end
				if (at_last) begin
					in_packet_q <= 1'b0;
					pos_q       <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/core/tsps_out_reg.sv
// tsps_out_reg: result register driving the master-side stream.
// Depends on tsps_pkg.
module tsps_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsps_pkg::result_t             res,
	input  logic                          load,
	output logic                          busy,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tsps_pkg::DATA_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic [0:0]                    m_tuser
);
	import tsps_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign busy     = valid_q && !m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.continuity_count, res_q.scrambling_mode,
		res_q.priority_flag, res_q.unit_start_flag, res_q.error_flag,
		res_q.stream_id, res_q.payload_byte};
	assign m_tlast  = res_q.last_of_packet;
	assign m_tuser  = res_q.first_payload;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule
